// File: rtl/lbc_pkg.sv
// Package: widths, geometry type and geometry lookup for the LBA to CHS converter.
package lbc_pkg;

  localparam int unsigned ADDR_W    = 32;  // logical block address
  localparam int unsigned CAP_W     = 24;  // capacity in megabytes
  localparam int unsigned PERCYL_W  = 14;  // heads * sectors per track, max 16065
  localparam int unsigned SPT_W     = 6;   // sectors per track, 32 or 63
  localparam int unsigned CYL_W     = 10;  // cylinder number
  localparam int unsigned HEAD_W    = 8;   // head number
  localparam int unsigned CYL_REM_W = 24;  // address bits left when the cylinder fits
  localparam int unsigned SIDE_W    = CYL_W + 1;

  localparam logic [HEAD_W-1:0] SAT_HEAD   = 8'd254;
  localparam logic [SPT_W-1:0]  SAT_SECTOR = 6'd63;
  localparam logic [CYL_W-1:0]  CYL_MAX    = 10'd1023;

  // Geometry derived from the capacity register
  typedef struct packed {
    logic [PERCYL_W-1:0] per_cyl;
    logic [SPT_W-1:0]    spt;
  } geo_t;

  // Geometry for zero capacity: 2 heads, 32 sectors per track
  localparam geo_t GEO_RESET = '{per_cyl: 14'd64, spt: 6'd32};

  function automatic geo_t geo_for(input logic [CAP_W-1:0] cap);
    logic [SPT_W-1:0]  spt;
    logic [HEAD_W-1:0] heads;
    geo_t              g;
    spt = (cap <= 24'd256) ? 6'd32 : 6'd63;
    if (cap <= 24'd16) begin
      heads = 8'd2;
    end else if (cap <= 24'd32) begin
      heads = 8'd4;
    end else if (cap <= 24'd128) begin
      heads = 8'd8;
    end else if (cap <= 24'd504) begin
      heads = 8'd16;
    end else if (cap <= 24'd1008) begin
      heads = 8'd32;
    end else if (cap <= 24'd2016) begin
      heads = 8'd64;
    end else if (cap <= 24'd4032) begin
      heads = 8'd128;
    end else begin
      heads = 8'd255;
    end
    g.per_cyl = PERCYL_W'(heads) * PERCYL_W'(spt);
    g.spt     = spt;
    return g;
  endfunction

endpackage

// File: rtl/lba_to_chs_converter.sv
// LBA to CHS converter: top level with divider pipeline and output register.
// Pipeline: four cylinder divider stages of 2-3 quotient bits, two head/sector stages
// of 4 bits, then the output register.
// Throughput: one word per cycle when not stalled; each stage holds its word while the next is stalled.
// Reset clears all valid bits and sets the geometry of zero capacity (2 heads, 32 spt).
module lba_to_chs_converter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lbc_pkg::CAP_W-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [lbc_pkg::ADDR_W-1:0]  block_address_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  head_byte_o,
  output logic [7:0]                  sector_cyl_high_byte_o,
  output logic [7:0]                  cyl_low_byte_o
);

  localparam int unsigned RW = lbc_pkg::CYL_REM_W;
  localparam int unsigned PW = lbc_pkg::PERCYL_W;
  localparam int unsigned SW = lbc_pkg::SPT_W;
  localparam int unsigned CW = lbc_pkg::CYL_W;
  localparam int unsigned HW = lbc_pkg::HEAD_W;
  localparam int unsigned XW = lbc_pkg::SIDE_W;

  lbc_pkg::geo_t geo;

  logic                              ovf;
  logic [4:0]                        vld;
  logic [4:0]                        rdy;
  logic [RW-1:0]                     crem [4];
  logic [CW-1:0]                     cquo [4];
  logic                              csat [4];
  logic [PW-1:0]                     hrem [2];
  logic [HW-1:0]                     hquo [2];
  logic [XW-1:0]                     hside [2];
  logic                              s6_valid;
  logic                              s6_ready;
  logic                              out_ready;
  logic                              out_valid_q;
  logic [HW-1:0]                     head_d, head_q;
  logic [SW-1:0]                     sect_d, sect_q;
  logic [CW-1:0]                     cyl_d, cyl_q;

  lbc_geometry u_geometry (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .geo_o       (geo)
  );

  // Cylinder above 1023 when the address reaches per_cyl * 1024
  assign ovf = block_address_i >= {{(lbc_pkg::ADDR_W - PW - CW){1'b0}}, geo.per_cyl,
                                   {CW{1'b0}}};

  // Cylinder division: quotient bits 9..8, 7..5, 4..2, 1..0
  lbc_div_stage #(.RemW(RW), .DivW(PW), .QuoW(CW), .TopBit(9), .Steps(2), .SideW(1))
  u_cyl0 (
    .clk_i (clk_i), .rst_ni (rst_ni),
    .valid_i (in_valid_i), .ready_o (rdy[0]),
    .rem_i (block_address_i[RW-1:0]), .quo_i ('0), .side_i (ovf), .div_i (geo.per_cyl),
    .valid_o (vld[0]), .ready_i (rdy[1]),
    .rem_o (crem[0]), .quo_o (cquo[0]), .side_o (csat[0])
  );

  lbc_div_stage #(.RemW(RW), .DivW(PW), .QuoW(CW), .TopBit(7), .Steps(3), .SideW(1))
  u_cyl1 (
    .clk_i (clk_i), .rst_ni (rst_ni),
    .valid_i (vld[0]), .ready_o (rdy[1]),
    .rem_i (crem[0]), .quo_i (cquo[0]), .side_i (csat[0]), .div_i (geo.per_cyl),
    .valid_o (vld[1]), .ready_i (rdy[2]),
    .rem_o (crem[1]), .quo_o (cquo[1]), .side_o (csat[1])
  );

  lbc_div_stage #(.RemW(RW), .DivW(PW), .QuoW(CW), .TopBit(4), .Steps(3), .SideW(1))
  u_cyl2 (
    .clk_i (clk_i), .rst_ni (rst_ni),
    .valid_i (vld[1]), .ready_o (rdy[2]),
    .rem_i (crem[1]), .quo_i (cquo[1]), .side_i (csat[1]), .div_i (geo.per_cyl),
    .valid_o (vld[2]), .ready_i (rdy[3]),
    .rem_o (crem[2]), .quo_o (cquo[2]), .side_o (csat[2])
  );

  lbc_div_stage #(.RemW(RW), .DivW(PW), .QuoW(CW), .TopBit(1), .Steps(2), .SideW(1))
  u_cyl3 (
    .clk_i (clk_i), .rst_ni (rst_ni),
    .valid_i (vld[2]), .ready_o (rdy[3]),
    .rem_i (crem[2]), .quo_i (cquo[2]), .side_i (csat[2]), .div_i (geo.per_cyl),
    .valid_o (vld[3]), .ready_i (rdy[4]),
    .rem_o (crem[3]), .quo_o (cquo[3]), .side_o (csat[3])
  );

  // Head and sector: remainder within the cylinder divided by sectors per track
  lbc_div_stage #(.RemW(PW), .DivW(SW), .QuoW(HW), .TopBit(7), .Steps(4), .SideW(XW))
  u_head0 (
    .clk_i (clk_i), .rst_ni (rst_ni),
    .valid_i (vld[3]), .ready_o (rdy[4]),
    .rem_i (crem[3][PW-1:0]), .quo_i ('0), .side_i ({csat[3], cquo[3]}),
    .div_i (geo.spt),
    .valid_o (vld[4]), .ready_i (s6_ready),
    .rem_o (hrem[0]), .quo_o (hquo[0]), .side_o (hside[0])
  );

  lbc_div_stage #(.RemW(PW), .DivW(SW), .QuoW(HW), .TopBit(3), .Steps(4), .SideW(XW))
  u_head1 (
    .clk_i (clk_i), .rst_ni (rst_ni),
    .valid_i (vld[4]), .ready_o (s6_ready),
    .rem_i (hrem[0]), .quo_i (hquo[0]), .side_i (hside[0]), .div_i (geo.spt),
    .valid_o (s6_valid), .ready_i (out_ready),
    .rem_o (hrem[1]), .quo_o (hquo[1]), .side_o (hside[1])
  );

  assign in_stall_o = !rdy[0];

  // Saturation and byte packing into the output register
  always_comb begin
    if (hside[1][CW]) begin
      head_d = lbc_pkg::SAT_HEAD;
      sect_d = lbc_pkg::SAT_SECTOR;
      cyl_d  = lbc_pkg::CYL_MAX;
    end else begin
      head_d = hquo[1];
      sect_d = SW'(hrem[1][SW-1:0] + SW'(1));
      cyl_d  = hside[1][CW-1:0];
    end
  end

  assign out_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s6_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s6_valid) begin
      head_q <= head_d;
      sect_q <= sect_d;
      cyl_q  <= cyl_d;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign head_byte_o            = head_q;
  assign sector_cyl_high_byte_o = {cyl_q[9:8], sect_q};
  assign cyl_low_byte_o         = cyl_q[7:0];

endmodule

// File: rtl/lbc_geometry.sv
// Capacity register write port and registered drive geometry.
module lbc_geometry (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lbc_pkg::CAP_W-1:0]  cfg_wdata_i,
  output lbc_pkg::geo_t              geo_o
);

  lbc_pkg::geo_t geo_q;

  // Geometry is looked up once on each register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geo_q <= lbc_pkg::GEO_RESET;
    end else if (cfg_we_i) begin
      geo_q <= lbc_pkg::geo_for(cfg_wdata_i);
    end
  end

  assign geo_o = geo_q;

endmodule

// File: rtl/lbc_div_stage.sv
// One pipeline stage of a restoring divider: a few quotient bits per stage.
module lbc_div_stage #(
  parameter int unsigned RemW   = 24,
  parameter int unsigned DivW   = 14,
  parameter int unsigned QuoW   = 10,
  parameter int unsigned TopBit = 9,
  parameter int unsigned Steps  = 2,
  parameter int unsigned SideW  = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [RemW-1:0]  rem_i,
  input  logic [QuoW-1:0]  quo_i,
  input  logic [SideW-1:0] side_i,
  input  logic [DivW-1:0]  div_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [RemW-1:0]  rem_o,
  output logic [QuoW-1:0]  quo_o,
  output logic [SideW-1:0] side_o
);

  localparam int unsigned WideW = RemW + DivW;

  logic [WideW-1:0] rem_w;
  logic [WideW-1:0] trial;
  logic [QuoW-1:0]  quo_w;
  logic             valid_q;
  logic [RemW-1:0]  rem_q;
  logic [QuoW-1:0]  quo_q;
  logic [SideW-1:0] side_q;

  // Compare and subtract the shifted divisor, top quotient bit first
  always_comb begin
    rem_w = WideW'(rem_i);
    quo_w = quo_i;
    trial = '0;
    for (int s = 0; s < Steps; s++) begin
      trial = WideW'(div_i) << (TopBit - s);
      if (rem_w >= trial) begin
        rem_w                = rem_w - trial;
        quo_w[TopBit - s]    = 1'b1;
      end
    end
  end

  // Stage moves on when empty or when the next stage takes its word
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rem_q  <= rem_w[RemW-1:0];
      quo_q  <= quo_w;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign side_o  = side_q;

endmodule
